// ===== hdl/ptd_pkg.sv =====
// Shared constants for the trial-division primality tester.
`default_nettype none
package ptd_pkg;

  // Default width of the tested number
  localparam int NUMBER_WIDTH = 32;

  // Divisor constants of the 6k +/- 1 scheme
  localparam int DIV_THREE = 3;
  localparam int DIV_FIRST = 5;
  localparam int DIV_GAP   = 2;
  localparam int DIV_STEP  = 6;

endpackage
`default_nettype wire

// ===== hdl/ptd_div.sv =====
// Radix-2 serial divider: one quotient bit per cycle, quotient and remainder held after done.
`default_nettype none
module ptd_div #(
  parameter int W = ptd_pkg::NUMBER_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  import ptd_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  dsr_r;

  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          borrow;
  logic [W-1:0]  rem_nxt;

  // Shift in the next dividend bit and try one subtraction
  assign rem_sh  = {rem_r, quo_r[W-1]};
  assign diff    = rem_sh - {1'b0, dsr_r};
  assign borrow  = diff[W];
  assign rem_nxt = borrow ? rem_sh[W-1:0] : diff[W-1:0];

  // Control: bit counter, busy and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[W-2:0], ~borrow};
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

  // A start always leads into a busy divider
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

endmodule
`default_nettype wire

// ===== hdl/prime_test_trial_division_top.sv =====
// Top level: primality test by trial division over 6k +/- 1 on a shared serial divider.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_ready, in_number  | request in
//  result  | out_valid, out_ready, out_is_prime | request out
//
// A request is taken only when the sequencer is idle. Trivial values (negative, below 4,
// even) go straight to the finish state; otherwise the serial divider is run once for 3
// and twice per candidate pair 6k +/- 1 up to sqrt(n): about 1 + 2*sqrt(n)/6 divisions.
// Reset is synchronous, active low, and clears the sequencer and output valid.
// A stalled result holds in the output register; the next request is accepted meanwhile.
`default_nettype none
module prime_test_trial_division_top #(
  parameter int NUMBER_WIDTH = ptd_pkg::NUMBER_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_is_prime
);
  import ptd_pkg::*;

  localparam int W = NUMBER_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV3,
    S_DIVA,
    S_DIVB,
    S_FIN
  } state_t;

  state_t       state_r;
  logic         res_r;
  logic         out_valid_r;
  logic         out_is_prime_r;
  logic         div_start_r;
  logic [W-1:0] num_r;
  logic [W-1:0] d_r;
  logic [W-1:0] dsr_r;

  logic         div_busy;
  logic         div_done;
  logic [W-1:0] div_quo;
  logic [W-1:0] div_rem;
  logic         in_acc;
  logic         rem_zero;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign rem_zero = (div_rem == '0);

  // Shared serial divider
  ptd_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (num_r),
    .divisor  (dsr_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      // drop a taken result; the finish state handles its own refill
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            num_r <= in_number;
            if (in_number[W-1]) begin
              // negative
              res_r   <= 1'b0;
              state_r <= S_FIN;
            end else if (in_number[W-2:2] == '0) begin
              // 0 and 1 are not prime, 2 and 3 are
              res_r   <= in_number[1];
              state_r <= S_FIN;
            end else if (!in_number[0]) begin
              res_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              dsr_r       <= W'(DIV_THREE);
              div_start_r <= 1'b1;
              state_r     <= S_DIV3;
            end
          end
        end
        S_DIV3: begin
          if (div_done) begin
            if (rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              d_r         <= W'(DIV_FIRST);
              dsr_r       <= W'(DIV_FIRST);
              div_start_r <= 1'b1;
              state_r     <= S_DIVA;
            end
          end
        end
        S_DIVA: begin
          if (div_done) begin
            if (d_r > div_quo) begin
              // d*d > n: no divisor found
              res_r   <= 1'b1;
              state_r <= S_FIN;
            end else if (rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              dsr_r       <= d_r + W'(DIV_GAP);
              div_start_r <= 1'b1;
              state_r     <= S_DIVB;
            end
          end
        end
        S_DIVB: begin
          if (div_done) begin
            if (rem_zero) begin
              res_r   <= 1'b0;
              state_r <= S_FIN;
            end else begin
              d_r         <= d_r + W'(DIV_STEP);
              dsr_r       <= d_r + W'(DIV_STEP);
              div_start_r <= 1'b1;
              state_r     <= S_DIVA;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_is_prime_r <= res_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  // The divider is never restarted while still working
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_busy)
    else $error("divider started while busy");

  // Candidates stay odd while the loop runs
  a_cand_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVA || state_r == S_DIVB) |-> d_r[0])
    else $error("trial divisor is even");

  // An accepted request leaves the idle state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("sequencer idle after accepting a request");

  // A divider start happens only on the way into a wait state
  a_start_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (state_r == S_DIV3 || state_r == S_DIVA || state_r == S_DIVB))
    else $error("divider started outside a division state");

endmodule
`default_nettype wire
